>>> rtl/adbl_pkg.sv
`default_nettype none

package adbl_pkg;

	// sample path formats
	localparam int FRAC_BITS   = 20;
	localparam int INPUT_SHIFT = 8;

	localparam int RAW_W   = 32;
	localparam int PCM_W   = 16;
	localparam int PEAK_W  = 16;
	localparam int COEF_W  = 20;
	localparam int LIM_W   = 15;
	localparam int ACC_W   = 46;
	localparam int ENV_W   = 45;
	localparam int X_W     = RAW_W - INPUT_SHIFT;
	localparam int DIFF_W  = X_W + 1;

	// shared multiplier: upper or lower part of a magnitude times a Q0.20 coefficient or the limit level
	localparam int MUL_A_W = ACC_W - COEF_W;
	localparam int MUL_B_W = COEF_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int RND_W   = COEF_W + 1;
	localparam int PM_W    = MUL_P_W + 1;
	localparam int SUM_W   = ((PM_W + 1) > (DIFF_W + FRAC_BITS) ?
		(PM_W + 1) : (DIFF_W + FRAC_BITS)) + 1;

	// limiter division
	localparam int QUOT_W  = 17;
	localparam int P_W     = ACC_W + LIM_W;
	localparam int PLO_W   = LIM_W + COEF_W;
	localparam int DIV_W   = ENV_W + QUOT_W;
	localparam int CMP_W   = (P_W > DIV_W) ? P_W : DIV_W;
	localparam int CNT_W   = $clog2(QUOT_W);

	localparam logic [QUOT_W-1:0] PCM_POS_MAX = QUOT_W'(32767);
	localparam logic [QUOT_W-1:0] PCM_NEG_MAX = QUOT_W'(32768);

	// configuration port
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 4;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_DC_POLE        = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_ENVELOPE_DECAY = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_LIMIT_LEVEL    = REG_IDX_W'(2);

	localparam logic [COEF_W-1:0] DC_POLE_RST        = COEF_W'(1043333);
	localparam logic [COEF_W-1:0] ENVELOPE_DECAY_RST = COEF_W'(1048261);
	localparam logic [LIM_W-1:0]  LIMIT_LEVEL_RST    = LIM_W'(14000);

	typedef struct packed {
		logic [COEF_W-1:0] dc_pole;
		logic [COEF_W-1:0] envelope_decay;
		logic [LIM_W-1:0]  limit_level;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POLE_LO,
		ST_POLE_HI,
		ST_DCB,
		ST_DECAY_HI,
		ST_ENV,
		ST_LIM_HI,
		ST_PROD,
		ST_DIV_CHK,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/adbl_in_if.sv
`default_nettype none

interface adbl_in_if import adbl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RAW_W-1:0] raw_word;

	modport source (output valid, output raw_word, input ready);
	modport sink   (input valid, input raw_word, output ready);
endinterface

`default_nettype wire

>>> rtl/adbl_out_if.sv
`default_nettype none

interface adbl_out_if import adbl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [PCM_W-1:0] pcm;
	logic [PEAK_W-1:0]       peak_level;
	logic                    limiting;

	modport source (output valid, output pcm, output peak_level, output limiting, input ready);
	modport sink   (input valid, input pcm, input peak_level, input limiting, output ready);
endinterface

`default_nettype wire

>>> rtl/adbl_mul.sv
`default_nettype none

module adbl_mul import adbl_pkg::*; (
	input  wire logic               clk,
	input  wire logic [MUL_A_W-1:0] a,
	input  wire logic [MUL_B_W-1:0] b,
	output logic      [MUL_P_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

`default_nettype wire

>>> rtl/adbl_regs.sv
`default_nettype none

module adbl_regs import adbl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dc_pole        <= DC_POLE_RST;
			cfg_q.envelope_decay <= ENVELOPE_DECAY_RST;
			cfg_q.limit_level    <= LIMIT_LEVEL_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DC_POLE:        cfg_q.dc_pole        <= pwdata[COEF_W-1:0];
				REG_ENVELOPE_DECAY: cfg_q.envelope_decay <= pwdata[COEF_W-1:0];
				REG_LIMIT_LEVEL:    cfg_q.limit_level    <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DC_POLE:        prdata = DATA_W'(cfg_q.dc_pole);
			REG_ENVELOPE_DECAY: prdata = DATA_W'(cfg_q.envelope_decay);
			REG_LIMIT_LEVEL:    prdata = DATA_W'(cfg_q.limit_level);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/adbl_core.sv
`default_nettype none

module adbl_core import adbl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	adbl_in_if.sink   sample,
	adbl_out_if.source result
);

	state_t state_q, state_d;

	// filter state
	logic [ACC_W-1:0]  hp_q;
	logic [X_W-1:0]    prev_q;
	logic [ENV_W-1:0]  env_q;
	logic [PEAK_W-1:0] peak_q;

	// per-sample working registers
	logic [X_W-1:0]    x_q;
	logic [RND_W-1:0]  rnd_q;
	logic [ACC_W-1:0]  a_q;
	logic              neg_q;
	logic [PLO_W-1:0]  plo_q;
	logic [P_W-1:0]    rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [QUOT_W-1:0] quot_q;
	logic              sat_q;
	logic              lim_q;
	logic [CNT_W-1:0]  cnt_q;

	// output word
	logic                    out_valid_q;
	logic signed [PCM_W-1:0] pcm_q;
	logic [PEAK_W-1:0]       peak_out_q;
	logic                    lim_out_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod_q;

	logic               accept;
	logic               out_free;
	logic               out_load;
	logic [ACC_W-1:0]   hp_mag;
	logic [MUL_P_W:0]   rnd_sum;
	logic [PM_W-1:0]    pm;
	logic [SUM_W-1:0]   pm_ext, pm_s, diff_ext, acc_sum;
	logic [DIFF_W-1:0]  diff;
	logic [SUM_W-ACC_W:0] acc_top;
	logic [ACC_W-1:0]   acc_sat;
	logic [ACC_W-1:0]   a_mag;
	logic [ENV_W-1:0]   ac;
	logic [ENV_W-1:0]   decayed;
	logic               ge;
	logic [ACC_W-1:0]   a_int;
	logic [QUOT_W-1:0]  m_sel;
	logic [PCM_W-1:0]   pcm_d;
	logic [PEAK_W-1:0]  pa;
	logic [PEAK_W-1:0]  peak_d;

	adbl_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	assign result.valid      = out_valid_q;
	assign result.pcm        = pcm_q;
	assign result.peak_level = peak_out_q;
	assign result.limiting   = lim_out_q;

	// datapath
	assign hp_mag  = hp_q[ACC_W-1] ? (~hp_q + ACC_W'(1)) : hp_q;
	assign rnd_sum = {1'b0, prod_q} + (MUL_P_W+1)'(1 << (COEF_W - 1));
	assign pm      = {1'b0, prod_q} + PM_W'(rnd_q);

	assign pm_ext   = SUM_W'(pm);
	assign pm_s     = hp_q[ACC_W-1] ? (~pm_ext + SUM_W'(1)) : pm_ext;
	assign diff     = {x_q[X_W-1], x_q} - {prev_q[X_W-1], prev_q};
	assign diff_ext = {{(SUM_W-DIFF_W-FRAC_BITS){diff[DIFF_W-1]}}, diff, {FRAC_BITS{1'b0}}};
	assign acc_sum  = pm_s + diff_ext;
	assign acc_top  = acc_sum[SUM_W-1:ACC_W-1];

	always_comb begin
		if ((&acc_top) || !(|acc_top)) begin
			acc_sat = acc_sum[ACC_W-1:0];
		end else if (acc_sum[SUM_W-1]) begin
			acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	assign a_mag   = acc_sat[ACC_W-1] ? (~acc_sat + ACC_W'(1)) : acc_sat;
	assign ac      = a_q[ACC_W-1] ? {ENV_W{1'b1}} : a_q[ENV_W-1:0];
	assign decayed = pm[ENV_W-1:0];
	assign ge      = CMP_W'(rem_q) >= CMP_W'(div_q);

	// final magnitude, clamp and peak meter
	assign a_int = a_q >> FRAC_BITS;

	always_comb begin
		if (lim_q) begin
			m_sel = sat_q ? {QUOT_W{1'b1}} : quot_q;
		end else if (|a_int[ACC_W-1:QUOT_W]) begin
			m_sel = {QUOT_W{1'b1}};
		end else begin
			m_sel = a_int[QUOT_W-1:0];
		end
	end

	always_comb begin
		if (neg_q) begin
			pa    = (m_sel > PCM_NEG_MAX) ? PEAK_W'(PCM_NEG_MAX) : m_sel[PEAK_W-1:0];
			pcm_d = ~pa + PCM_W'(1);
		end else begin
			pa    = (m_sel > PCM_POS_MAX) ? PEAK_W'(PCM_POS_MAX) : m_sel[PEAK_W-1:0];
			pcm_d = pa;
		end
	end

	always_comb begin
		if (pa > peak_q) begin
			peak_d = pa;
		end else if (peak_q != '0) begin
			peak_d = peak_q - PEAK_W'(1);
		end else begin
			peak_d = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (sample.valid) state_d = ST_POLE_LO;
			ST_POLE_LO:  state_d = ST_POLE_HI;
			ST_POLE_HI:  state_d = ST_DCB;
			ST_DCB:      state_d = ST_DECAY_HI;
			ST_DECAY_HI: state_d = ST_ENV;
			ST_ENV:      state_d = ST_LIM_HI;
			ST_LIM_HI:   state_d = ST_PROD;
			ST_PROD: begin
				if (env_q > (ENV_W'(cfg.limit_level) << FRAC_BITS)) state_d = ST_DIV_CHK;
				else state_d = ST_DONE;
			end
			ST_DIV_CHK:  state_d = ge ? ST_DONE : ST_DIV;
			ST_DIV:      if (cnt_q == '0) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		sample.ready = 1'b0;
		out_load     = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		unique case (state_q)
			ST_IDLE:     sample.ready = 1'b1;
			ST_POLE_LO: begin
				mul_a = MUL_A_W'(hp_mag[COEF_W-1:0]);
				mul_b = cfg.dc_pole;
			end
			ST_POLE_HI: begin
				mul_a = hp_mag[ACC_W-1:COEF_W];
				mul_b = cfg.dc_pole;
			end
			ST_DCB: begin
				mul_a = MUL_A_W'(env_q[COEF_W-1:0]);
				mul_b = cfg.envelope_decay;
			end
			ST_DECAY_HI: begin
				mul_a = MUL_A_W'(env_q[ENV_W-1:COEF_W]);
				mul_b = cfg.envelope_decay;
			end
			ST_ENV: begin
				mul_a = MUL_A_W'(a_q[COEF_W-1:0]);
				mul_b = MUL_B_W'(cfg.limit_level);
			end
			ST_LIM_HI: begin
				mul_a = a_q[ACC_W-1:COEF_W];
				mul_b = MUL_B_W'(cfg.limit_level);
			end
			ST_DONE:     out_load = out_free;
			default: ;
		endcase
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hp_q        <= '0;
			prev_q      <= '0;
			env_q       <= '0;
			peak_q      <= '0;
			lim_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DCB) begin
				hp_q   <= acc_sat;
				prev_q <= x_q;
			end
			if (state_q == ST_ENV) env_q <= (ac > env_q) ? ac : decayed;
			if (state_q == ST_PROD) lim_q <= env_q > (ENV_W'(cfg.limit_level) << FRAC_BITS);
			if (state_q == ST_DIV_CHK) cnt_q <= CNT_W'(QUOT_W - 1);
			else if (state_q == ST_DIV) cnt_q <= cnt_q - CNT_W'(1);
			if (out_load) begin
				peak_q      <= peak_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and output word
	always_ff @(posedge clk) begin
		if (accept) x_q <= sample.raw_word[RAW_W-1:INPUT_SHIFT];
		unique case (state_q)
			ST_POLE_HI, ST_DECAY_HI: rnd_q <= rnd_sum[COEF_W +: RND_W];
			ST_DCB: begin
				a_q   <= a_mag;
				neg_q <= acc_sat[ACC_W-1];
			end
			ST_LIM_HI: plo_q <= prod_q[PLO_W-1:0];
			ST_PROD: begin
				rem_q  <= P_W'({prod_q, {COEF_W{1'b0}}}) + P_W'(plo_q);
				div_q  <= {env_q, {QUOT_W{1'b0}}};
				quot_q <= '0;
				sat_q  <= 1'b0;
			end
			ST_DIV_CHK: begin
				sat_q <= ge;
				div_q <= div_q >> 1;
			end
			ST_DIV: begin
				if (ge) rem_q <= rem_q - P_W'(div_q);
				quot_q <= {quot_q[QUOT_W-2:0], ge};
				div_q  <= div_q >> 1;
			end
			default: ;
		endcase
		if (out_load) begin
			pcm_q      <= pcm_d;
			peak_out_q <= peak_d;
			lim_out_q  <= lim_q;
		end
	end

	// a new word always starts with the low half of the pole product
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_POLE_LO)
		else $error("sequencer did not start after a sample was taken");

	// only a limited sample with a nonzero envelope is divided
	a_div_lim: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> lim_q && (env_q != '0))
		else $error("division entered without limiting");

	// restoring division keeps the remainder below twice the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (CMP_W+1)'(rem_q) < ((CMP_W+1)'(div_q) << 1))
		else $error("division remainder out of range");

	// a result appears only from the final step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result word raised outside the final step");

endmodule

`default_nettype wire

>>> rtl/audio_dc_block_limiter_top.sv
// sequence: a taken word runs through the multiply states; with gain reduction it then
//   runs up to the full 17-step division before its result is loaded into the output
// input: a new word is taken only in idle, after six passes through the one shared
//   26x20 multiplier and, when limiting, the one-bit-per-cycle restoring divider of the limiter
// reset: arst_n clears filter, envelope and peak state at once; registers return to
//   their default coefficients and limit; no clearing pass
`default_nettype none

module audio_dc_block_limiter_top import adbl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	adbl_in_if.sink                sample,
	adbl_out_if.source             result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	// coefficient and limit registers: user writes only while no word is in flight
	cfg_t cfg;

	adbl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: dc blocker, envelope follower, limiter divide, clamp and peak meter;
	// the result word sits in an output register so the next word can be taken
	// while the previous result is still waiting on the sink
	adbl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

endmodule

`default_nettype wire

>>> tb/tb_audio_dc_block_limiter_top.sv
`timescale 1ns / 1ps

module tb_audio_dc_block_limiter_top;
	import adbl_pkg::*;

	// timing of the run
	localparam int  SETTLE_CYCLES = 40;         // above the worst-case latency
	localparam int  CYCLE_LIMIT   = 1000000;
	localparam int  HOLD_FIRST    = 200;        // words taken before the first long stall
	localparam int  HOLD_EVERY    = 500;
	localparam int  HOLD_LEN      = 600;        // cycles the receiver holds off
	localparam int  RANDOM_WORDS  = 200;        // random words in each phase with random audio

	// fixed-point limits of the sample path
	localparam longint          ACC_HI  = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint          ACC_LO  = -(longint'(1) <<< (ACC_W - 1));
	localparam longint unsigned ENV_TOP = (64'd1 << ENV_W) - 1;
	localparam longint unsigned HALF_LSB = 64'd1 << (COEF_W - 1);

	typedef struct {
		logic signed [PCM_W-1:0] pcm;
		logic [PEAK_W-1:0]       peak_level;
		logic                    limiting;
	} sample_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	adbl_in_if  sample_if ();
	adbl_out_if result_if ();

	audio_dc_block_limiter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// words waiting for the driver, results waiting for the monitor
	logic signed [RAW_W-1:0] raw_words_pending[$];
	sample_result_t          expected_results[$];

	// shadow of the configuration registers
	logic [COEF_W-1:0] pole_cfg;
	logic [COEF_W-1:0] decay_cfg;
	logic [LIM_W-1:0]  limit_cfg;

	// shadow of the filter state
	longint            hp_acc;
	longint            prev_x;
	longint unsigned   env_level;
	logic [PEAK_W-1:0] peak_hold;

	int words_taken;
	int results_seen;
	int mismatches;
	int cycle_count;
	int burst_left;
	int gap_left;
	int hold_left;
	int hold_at;
	logic [15:0] stall_pattern;
	logic [5:0]  pattern_age;

	always #5 clk = ~clk;

	// |v| times an unsigned Q0.20 coefficient, rounded to nearest with ties going up
	function automatic longint unsigned coef_scale(longint unsigned mag, logic [COEF_W-1:0] coef);
		longint unsigned upper;
		longint unsigned lower;
		upper = mag >> COEF_W;
		lower = mag & ((64'd1 << COEF_W) - 1);
		return upper * coef + ((lower * coef + HALF_LSB) >> COEF_W);
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// one sample through the DC blocker, envelope, limiter and peak meter
	function automatic sample_result_t condition_sample(logic signed [RAW_W-1:0] raw);
		longint          x;
		longint          scaled;
		longint          acc;
		longint          pcm_v;
		longint unsigned pm;
		longint unsigned a;
		longint unsigned ac;
		longint unsigned m;
		longint unsigned limit_fx;
		logic            lim;
		logic [PEAK_W-1:0] pa;
		sample_result_t  r;

		// arithmetic shift floors toward minus infinity
		x = longint'(raw >>> INPUT_SHIFT);

		// dc blocker with rounding on magnitudes, then saturation to 46 bits
		pm = coef_scale(magnitude(hp_acc), pole_cfg);
		scaled = (hp_acc < 0) ? -longint'(pm) : longint'(pm);
		acc = scaled + (x - prev_x) * (longint'(1) <<< FRAC_BITS);
		if (acc > ACC_HI)
			acc = ACC_HI;
		if (acc < ACC_LO)
			acc = ACC_LO;
		hp_acc = acc;
		prev_x = x;

		// envelope jumps up to the capped magnitude, else decays
		a = magnitude(acc);
		ac = (a > ENV_TOP) ? ENV_TOP : a;
		if (ac > env_level)
			env_level = ac;
		else
			env_level = coef_scale(env_level, decay_cfg);

		// gain reduction by limit/envelope, truncated toward zero
		limit_fx = longint'(limit_cfg) << FRAC_BITS;
		lim = (env_level > limit_fx);
		if (lim)
			m = (a * longint'(limit_cfg)) / env_level;
		else
			m = a >> FRAC_BITS;
		if (acc < 0)
			pcm_v = (m > 32768) ? -32768 : -longint'(m);
		else
			pcm_v = (m > 32767) ? 32767 : longint'(m);

		// peak meter: instant rise, fall by one
		pa = PEAK_W'((pcm_v < 0) ? -pcm_v : pcm_v);
		if (pa > peak_hold)
			peak_hold = pa;
		else if (peak_hold != 0)
			peak_hold = peak_hold - 1'b1;

		r.pcm = PCM_W'(pcm_v);
		r.peak_level = peak_hold;
		r.limiting = lim;
		return r;
	endfunction

	function automatic logic signed [RAW_W-1:0] sat_raw(longint v);
		if (v > 64'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000)
			return 32'sh8000_0000;
		return RAW_W'(v);
	endfunction

	// sender: bursts of random length with random gaps, valid held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
			sample_if.raw_word <= '0;
			burst_left <= 1;
			gap_left <= 0;
			words_taken <= 0;
		end else begin
			if (sample_if.valid && sample_if.ready) begin
				expected_results.push_back(condition_sample(sample_if.raw_word));
				words_taken <= words_taken + 1;
			end
			if (!sample_if.valid || sample_if.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					sample_if.valid <= 1'b0;
				end else if (raw_words_pending.size() != 0) begin
					sample_if.valid <= 1'b1;
					sample_if.raw_word <= raw_words_pending.pop_front();
					if (burst_left <= 1) begin
						// some bursts run back to back with no idle at all
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-offs so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_at <= HOLD_FIRST;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (words_taken >= hold_at) begin
			hold_left <= HOLD_LEN;
			hold_at <= hold_at + HOLD_EVERY;
		end
	end

	// receiver: checks each word against the oldest expectation, stalls on a rotating pattern
	always @(posedge clk or negedge arst_n) begin
		sample_result_t exp_r;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_pattern <= 16'hFFFF;
			pattern_age <= '0;
			results_seen <= 0;
			mismatches <= 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected word %0d: pcm %0d peak %0d limiting %0b",
							results_seen, result_if.pcm, result_if.peak_level,
							result_if.limiting);
				end else begin
					exp_r = expected_results.pop_front();
					if (result_if.pcm !== exp_r.pcm || result_if.peak_level !== exp_r.peak_level
							|| result_if.limiting !== exp_r.limiting) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10) begin
							$write("mismatch at word %0d: pcm exp %0d got %0d, ",
								results_seen, exp_r.pcm, result_if.pcm);
							$display("peak exp %0d got %0d, limiting exp %0b got %0b",
								exp_r.peak_level, result_if.peak_level,
								exp_r.limiting, result_if.limiting);
						end
					end
				end
			end
			// new stall pattern each time the 6-bit age counter wraps: open, random, sparse or dense
			pattern_age <= pattern_age + 1'b1;
			if (pattern_age == '1) begin
				case ($urandom_range(0, 3))
					0: stall_pattern <= 16'hFFFF;
					1: stall_pattern <= 16'($urandom);
					2: stall_pattern <= 16'($urandom & $urandom);
					default: stall_pattern <= 16'($urandom | $urandom);
				endcase
			end else begin
				stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
			end
			result_if.ready <= (hold_left == 0) && stall_pattern[0];
		end
	end

	// register write: setup then access, done when pready is seen in the access phase
	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DC_POLE:        pole_cfg = value[COEF_W-1:0];
			REG_ENVELOPE_DECAY: decay_cfg = value[COEF_W-1:0];
			REG_LIMIT_LEVEL:    limit_cfg = value[LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int pole, int decay, int limit);
		reg_write(REG_DC_POLE, DATA_W'(pole));
		reg_write(REG_ENVELOPE_DECAY, DATA_W'(decay));
		reg_write(REG_LIMIT_LEVEL, DATA_W'(limit));
	endtask

	// everything sent and answered, then a latency's worth of quiet
	task automatic wait_idle();
		do @(negedge clk);
		while (raw_words_pending.size() != 0 || sample_if.valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// audio-like segments with random content and some noise mixed in
	task automatic queue_audio(int count);
		int     left;
		int     len;
		int     kind;
		int     period;
		longint amp;
		longint dc;
		longint lvl;
		longint step;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(4, 48);
			if (len > left)
				len = left;
			amp = longint'(1) << $urandom_range(8, 31);
			dc = longint'($signed($urandom)) >>> $urandom_range(1, 31);
			step = amp >> $urandom_range(0, 6);
			if (step == 0)
				step = 1;
			period = $urandom_range(2, 16);
			lvl = dc;
			for (int i = 0; i < len; i++) begin
				case (kind)
					0: raw_words_pending.push_back(RAW_W'($urandom));
					1: raw_words_pending.push_back('0);
					2, 3, 4: begin
						// triangle around an offset
						lvl += step;
						if (lvl - dc > amp || dc - lvl > amp)
							step = -step;
						raw_words_pending.push_back(sat_raw(lvl + $urandom_range(0, 255)));
					end
					5, 6: raw_words_pending.push_back(
						sat_raw((i % period < period / 2) ? dc + amp : dc - amp));
					7: raw_words_pending.push_back(sat_raw(dc + $urandom_range(0, 4095)));
					8: raw_words_pending.push_back(($urandom_range(0, 7) == 0) ?
						RAW_W'($urandom) : '0);
					default: raw_words_pending.push_back(($urandom_range(0, 1) == 0) ?
						RAW_W'($urandom) : sat_raw(dc));
				endcase
			end
			left -= len;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_if.valid = 1'b0;
		sample_if.raw_word = '0;
		result_if.ready = 1'b0;
		pole_cfg = DC_POLE_RST;
		decay_cfg = ENVELOPE_DECAY_RST;
		limit_cfg = LIMIT_LEVEL_RST;
		hp_acc = 0;
		prev_x = 0;
		env_level = 0;
		peak_hold = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset coefficients: full-scale swings, floor shift at the low byte, silence
		raw_words_pending = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'shFFFF_FFFF, 32'sh0000_00FF, 32'sh0000_0100, 32'shFFFF_FF00,
			32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FF00,
			32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0001,
			32'sh0000_0000, 32'sh0000_0000};
		wait_idle();

		// zero limit: any nonzero envelope limits and pcm goes to zero
		set_config(DC_POLE_RST, ENVELOPE_DECAY_RST, 0);
		raw_words_pending = '{32'sh4000_0000, 32'shC000_0000, 32'sh0000_0000, 32'sh0000_0000,
			32'sh0000_0100};
		wait_idle();

		// no feedback, instant decay, top limit: ramps reach both clamp values
		set_config(0, 0, 32767);
		raw_words_pending = '{32'sh0000_0000, 32'shF000_0000, 32'shE000_0000, 32'shD000_0000,
			32'sh0000_0000, 32'sh1000_0000, 32'sh2000_0000, 32'sh3000_0000};
		queue_audio(RANDOM_WORDS);
		wait_idle();

		// full-scale feedback and decay, smallest nonzero limit
		set_config(20'hFFFFF, 20'hFFFFF, 1);
		queue_audio(RANDOM_WORDS);
		wait_idle();

		// random coefficients, mostly near unity as in real use
		for (int p = 0; p < 3; p++) begin
			set_config((p == 0) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(1030000, 20'hFFFFF),
				(p == 1) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(1040000, 20'hFFFFF),
				$urandom_range(1, 32767));
			queue_audio(RANDOM_WORDS);
			wait_idle();
		end

		// back to the defaults
		set_config(DC_POLE_RST, ENVELOPE_DECAY_RST, LIMIT_LEVEL_RST);
		queue_audio(RANDOM_WORDS);
		wait_idle();

		if (mismatches == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/adbl_pkg.sv
rtl/adbl_in_if.sv
rtl/adbl_out_if.sv
rtl/adbl_mul.sv
rtl/adbl_regs.sv
rtl/adbl_core.sv
rtl/audio_dc_block_limiter_top.sv
tb/tb_audio_dc_block_limiter_top.sv
